/* hdl/velocity_to_pwm_register_writes_top_defines.svh */
// assertion macros for the velocity to pwm register write block
// no dependencies, taken in by the top level
`ifndef VELOCITY_TO_PWM_REGISTER_WRITES_TOP_DEFINES_SVH
`define VELOCITY_TO_PWM_REGISTER_WRITES_TOP_DEFINES_SVH

// same-cycle implication, reset gated
`define VTPRW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset gated
`define VTPRW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/vtprw_pkg.sv */
// shared types and constants for the velocity to pwm register write block
// no dependencies
package vtprw_pkg;

    typedef struct packed {
        logic               motor_select;
        logic signed [15:0] velocity_cmd;
    } in_item_t;

    typedef struct packed {
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
        logic       block_member;
        logic       last_write;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  left_reverse_channel;
        logic [3:0]  left_forward_channel;
        logic [3:0]  right_reverse_channel;
        logic [3:0]  right_forward_channel;
        logic [14:0] max_speed;
        logic [14:0] deadband;
        logic        negate_left;
        logic        negate_right;
    } cfg_t;

    typedef enum logic [1:0] {
        DRV_OFF,
        DRV_ON,
        DRV_PART
    } drive_kind_t;

    // one queued command: first channel always goes full-off
    typedef struct packed {
        logic [3:0]  first_ch;
        logic [3:0]  second_ch;
        drive_kind_t kind;
        logic [11:0] duty;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_REV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_FWD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_REV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_FWD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_LEFT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RIGHT  = 3'd7;

    localparam logic [14:0] MAX_SPEED_RST = 15'd2560;
    localparam logic [14:0] MIN_SPEED     = 15'd26;
    localparam logic [14:0] MAX_DEADBAND  = 15'd19661;
    localparam logic [16:0] FRAC_ONE      = 17'h10000;

    localparam logic [7:0] BASE_ADDR = 8'h06;
    localparam logic [7:0] FULL_BIT  = 8'h10;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam logic [1:0] OFS_ON_L  = 2'd0;
    localparam logic [1:0] OFS_ON_H  = 2'd1;
    localparam logic [1:0] OFS_OFF_L = 2'd2;
    localparam logic [1:0] OFS_OFF_H = 2'd3;

    localparam int DIV_STAGES = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [2:0] LAST_STEP_SHORT = 3'd3;
    localparam logic [2:0] LAST_STEP_LONG  = 3'd5;

endpackage

/* hdl/vtprw_front.sv */
// front end: sign handling, pipelined fraction divider, deadband, off count
// depends on vtprw_pkg
module vtprw_front #(
    parameter int DUTY_MAX = 4095
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  vtprw_pkg::cfg_t     cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  vtprw_pkg::in_item_t s_item,
    input  vtprw_pkg::q_stat_t  q_stat,
    output logic                push_valid,
    output vtprw_pkg::desc_t    push_desc
);

    localparam int OFF_W  = $clog2(DUTY_MAX + 1);
    localparam int PROD_W = 17 + OFF_W + 1;
    localparam int NSTG   = vtprw_pkg::DIV_STAGES;

    typedef struct packed {
        logic        sel;
        logic        neg;
        logic        sat;
        logic [14:0] rem;
        logic [15:0] quo;
    } div_t;

    function automatic div_t div_step(input div_t d, input logic b, input logic [14:0] m);
        logic [15:0] t;
        div_t        r;
        r = d;
        t = {d.rem, b};
        if (t >= {1'b0, m}) begin
            r.rem = 15'(t - {1'b0, m});
            r.quo = {d.quo[14:0], 1'b1};
        end else begin
            r.rem = t[14:0];
            r.quo = {d.quo[14:0], 1'b0};
        end
        return r;
    endfunction

    div_t        pipe_reg  [0:NSTG];
    div_t        pipe_next [0:NSTG];
    logic [NSTG:0] vld_reg;
    logic [NSTG:0] vld_next;

    logic [16:0] frac_reg, frac_next;
    logic        fneg_reg, fneg_next;
    logic        fsel_reg, fsel_next;
    logic        fvld_reg, fvld_next;

    logic [14:0] ms, db;
    logic [15:0] lo;
    logic        adv;
    logic        inv;
    logic [16:0] ext, mag17;
    logic [15:0] mag;
    logic [16:0] frac_raw;
    logic [PROD_W-1:0] prod;
    logic [OFF_W-1:0]  off;
    logic [3:0]  rev_ch, fwd_ch;

    // clamp config limits
    always_comb begin
        ms = (cfg.max_speed < vtprw_pkg::MIN_SPEED) ? vtprw_pkg::MIN_SPEED : cfg.max_speed;
        db = (cfg.deadband > vtprw_pkg::MAX_DEADBAND) ? vtprw_pkg::MAX_DEADBAND
                                                       : cfg.deadband;
        lo = {2'b00, ms[14:1]};
    end

    assign adv        = !(fvld_reg && q_stat.full);
    assign s_ready    = adv;
    assign push_valid = fvld_reg && !q_stat.full;

    always_comb begin
        inv   = s_item.motor_select ? cfg.negate_right : cfg.negate_left;
        ext   = {s_item.velocity_cmd[15], s_item.velocity_cmd};
        mag17 = s_item.velocity_cmd[15] ? 17'(~ext + 17'd1) : ext;
        mag   = mag17[15:0];

        pipe_next[0].sel = s_item.motor_select;
        pipe_next[0].neg = inv ? (!s_item.velocity_cmd[15] && (s_item.velocity_cmd != '0))
                               : s_item.velocity_cmd[15];
        pipe_next[0].sat = (mag >= {1'b0, ms});
        pipe_next[0].rem = pipe_next[0].sat ? '0 : mag[14:0];
        pipe_next[0].quo = '0;
        vld_next[0]      = s_valid;

        for (int i = 1; i <= NSTG; i++) begin
            pipe_next[i] = div_step(pipe_reg[i-1], lo[NSTG-i], ms);
            vld_next[i]  = vld_reg[i-1];
        end

        frac_raw  = pipe_reg[NSTG].sat ? vtprw_pkg::FRAC_ONE : {1'b0, pipe_reg[NSTG].quo};
        frac_next = (frac_raw < {2'b00, db}) ? '0 : frac_raw;
        fneg_next = pipe_reg[NSTG].neg;
        fsel_next = pipe_reg[NSTG].sel;
        fvld_next = vld_reg[NSTG];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            fvld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg  <= vld_next;
            fvld_reg <= fvld_next;
        end
        if (adv) begin
            for (int i = 0; i <= NSTG; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
            frac_reg <= frac_next;
            fneg_reg <= fneg_next;
            fsel_reg <= fsel_next;
        end
    end

    // off count and write plan
    always_comb begin
        prod   = PROD_W'(frac_reg) * PROD_W'(DUTY_MAX) + PROD_W'(32768);
        off    = prod[16 +: OFF_W];
        rev_ch = fsel_reg ? cfg.right_reverse_channel : cfg.left_reverse_channel;
        fwd_ch = fsel_reg ? cfg.right_forward_channel : cfg.left_forward_channel;

        if (fneg_reg && (frac_reg != '0)) begin
            push_desc.first_ch  = fwd_ch;
            push_desc.second_ch = rev_ch;
        end else begin
            push_desc.first_ch  = rev_ch;
            push_desc.second_ch = fwd_ch;
        end
        if (off == '0) begin
            push_desc.kind = vtprw_pkg::DRV_OFF;
        end else if (off >= OFF_W'(DUTY_MAX)) begin
            push_desc.kind = vtprw_pkg::DRV_ON;
        end else begin
            push_desc.kind = vtprw_pkg::DRV_PART;
        end
        push_desc.duty = 12'(off);
    end

endmodule

/* hdl/vtprw_fifo.sv */
// short queue of write plans between front and back end
// depends on vtprw_pkg
module vtprw_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  vtprw_pkg::desc_t    push_desc,
    input  logic                pop,
    output vtprw_pkg::desc_t    head,
    output vtprw_pkg::q_stat_t  stat
);

    localparam int AW = vtprw_pkg::FIFO_AW;

    vtprw_pkg::desc_t mem_reg [0:vtprw_pkg::FIFO_DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (AW+1)'(vtprw_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* hdl/vtprw_back.sv */
// back end: steps through one write plan, one register write per cycle while m_ready allows
// depends on vtprw_pkg
module vtprw_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vtprw_pkg::desc_t     head,
    input  vtprw_pkg::q_stat_t   q_stat,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vtprw_pkg::out_item_t m_item
);

    vtprw_pkg::desc_t     cur_reg;
    logic                 cur_vld_reg, cur_vld_next;
    logic [2:0]           step_reg, step_next;
    logic                 m_valid_reg, m_valid_next;
    vtprw_pkg::out_item_t m_item_reg;

    vtprw_pkg::out_item_t wr;
    logic [3:0] ch;
    logic [1:0] ofs;
    logic [2:0] last_step;
    logic       out_free, emit, done;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        last_step = (cur_reg.kind == vtprw_pkg::DRV_PART) ? vtprw_pkg::LAST_STEP_LONG
                                                          : vtprw_pkg::LAST_STEP_SHORT;
        ch              = (step_reg < 3'd2) ? cur_reg.first_ch : cur_reg.second_ch;
        ofs             = vtprw_pkg::OFS_ON_H;
        wr.reg_data     = vtprw_pkg::ZERO_BYTE;
        wr.block_member = 1'b0;
        case (step_reg)
            3'd0: begin
                ofs = vtprw_pkg::OFS_ON_H;
            end
            3'd1: begin
                ofs         = vtprw_pkg::OFS_OFF_H;
                wr.reg_data = vtprw_pkg::FULL_BIT;
            end
            3'd2: begin
                case (cur_reg.kind)
                    vtprw_pkg::DRV_OFF:  ofs = vtprw_pkg::OFS_ON_H;
                    vtprw_pkg::DRV_ON:   ofs = vtprw_pkg::OFS_OFF_H;
                    default: begin
                        ofs             = vtprw_pkg::OFS_ON_L;
                        wr.block_member = 1'b1;
                    end
                endcase
            end
            3'd3: begin
                case (cur_reg.kind)
                    vtprw_pkg::DRV_OFF: begin
                        ofs         = vtprw_pkg::OFS_OFF_H;
                        wr.reg_data = vtprw_pkg::FULL_BIT;
                    end
                    vtprw_pkg::DRV_ON: begin
                        ofs         = vtprw_pkg::OFS_ON_H;
                        wr.reg_data = vtprw_pkg::FULL_BIT;
                    end
                    default: begin
                        ofs             = vtprw_pkg::OFS_ON_H;
                        wr.block_member = 1'b1;
                    end
                endcase
            end
            3'd4: begin
                ofs             = vtprw_pkg::OFS_OFF_L;
                wr.reg_data     = cur_reg.duty[7:0];
                wr.block_member = 1'b1;
            end
            default: begin
                ofs             = vtprw_pkg::OFS_OFF_H;
                wr.reg_data     = {4'h0, cur_reg.duty[11:8]};
                wr.block_member = 1'b1;
            end
        endcase
        wr.reg_addr   = vtprw_pkg::BASE_ADDR + {2'b00, ch, 2'b00} + {6'b000000, ofs};
        wr.last_write = (step_reg == last_step);

        out_free     = !m_valid_reg || m_ready;
        emit         = cur_vld_reg && out_free;
        done         = emit && (step_reg == last_step);
        pop          = !q_stat.empty && (!cur_vld_reg || done);
        cur_vld_next = pop ? 1'b1 : (done ? 1'b0 : cur_vld_reg);
        step_next    = pop ? 3'd0 : (emit ? step_reg + 3'd1 : step_reg);
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_vld_reg <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_vld_reg <= cur_vld_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
        if (pop) begin
            cur_reg <= head;
        end
        if (emit) begin
            m_item_reg <= wr;
        end
    end

endmodule

/* hdl/velocity_to_pwm_register_writes_top.sv */
// top level of the velocity to pwm register write block
// depends on vtprw_pkg, vtprw_front, vtprw_fifo, vtprw_back and the defines header
//
// s_ channel: one item is a motor select and a signed q7.8 velocity command.
// m_ channel: one item is one register write for the pwm controller; every
// command gives four or six writes, the final one flagged by last_write.
// cfg port: write enable, register index and data, taken in one cycle, to be
// used only while no command is in flight.
// path: a command passes through registered sign handling, 16 stages of the
// restoring divider (one quotient bit each), the registered deadband step, the
// queue and the write sequencer before its first write is shown.
// throughput: the sequencer emits one write per cycle while m_ready allows, so a
// command occupies it for four or six writes; the front takes a command every
// cycle until the four-entry queue is full and its last stage holds a command.
// reset: configuration returns to its defaults, pipeline, queue and output
// are emptied; no clearing pass is needed.
// stall: while m_ready is low the output write holds, the sequencer and then
// the queue fill, and s_ready drops once the last front stage cannot drain.
`include "velocity_to_pwm_register_writes_top_defines.svh"

module velocity_to_pwm_register_writes_top #(
    parameter int DUTY_MAX = 4095
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [vtprw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vtprw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vtprw_pkg::in_item_t                 s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vtprw_pkg::out_item_t                m_item
);

    vtprw_pkg::cfg_t    cfg_reg, cfg_next;
    vtprw_pkg::q_stat_t q_stat;
    vtprw_pkg::desc_t   push_desc, head;
    logic               push_valid, pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                vtprw_pkg::REG_LEFT_REV:  cfg_next.left_reverse_channel  = cfg_wdata[3:0];
                vtprw_pkg::REG_LEFT_FWD:  cfg_next.left_forward_channel  = cfg_wdata[3:0];
                vtprw_pkg::REG_RIGHT_REV: cfg_next.right_reverse_channel = cfg_wdata[3:0];
                vtprw_pkg::REG_RIGHT_FWD: cfg_next.right_forward_channel = cfg_wdata[3:0];
                vtprw_pkg::REG_MAX_SPEED: cfg_next.max_speed             = cfg_wdata;
                vtprw_pkg::REG_DEADBAND:  cfg_next.deadband              = cfg_wdata;
                vtprw_pkg::REG_INV_LEFT:  cfg_next.negate_left           = cfg_wdata[0];
                vtprw_pkg::REG_INV_RIGHT: cfg_next.negate_right          = cfg_wdata[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_reverse_channel  <= 4'd0;
            cfg_reg.left_forward_channel  <= 4'd1;
            cfg_reg.right_reverse_channel <= 4'd2;
            cfg_reg.right_forward_channel <= 4'd3;
            cfg_reg.max_speed             <= vtprw_pkg::MAX_SPEED_RST;
            cfg_reg.deadband              <= '0;
            cfg_reg.negate_left           <= 1'b0;
            cfg_reg.negate_right          <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    vtprw_front #(
        .DUTY_MAX (DUTY_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_desc  (push_desc)
    );

    vtprw_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    vtprw_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    `VTPRW_ASSERT_NOW(a_single_data, aclk, aresetn, m_valid && !m_item.block_member, (m_item.reg_data == vtprw_pkg::FULL_BIT) || (m_item.reg_data == vtprw_pkg::ZERO_BYTE), "single write data is neither full bit nor zero")
    `VTPRW_ASSERT_NOW(a_off_h_nibble, aclk, aresetn, m_valid && m_item.block_member && (m_item.reg_addr[1:0] == 2'b01), m_item.reg_data[7:4] == 4'h0, "block off high byte has upper bits set")
    `VTPRW_ASSERT_NEXT(a_no_double_last, aclk, aresetn, m_valid && m_ready && m_item.last_write, !m_valid || !m_item.last_write, "last write directly follows a last write")
    `VTPRW_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, q_stat.full, "input stalled with room in the queue")

endmodule
